@@ rtl/core/oul_pkg.sv @@
// oul_pkg: types and codes shared by the ordered unique id list unit
// request/result payload structs, operation and status codes, sequencer states
// no dependencies
package oul_pkg;

  localparam int DepthDefault   = 16;
  localparam int KeyBitsDefault = 32;

  localparam int KEY_FIELD_W    = 32;
  localparam int POS_FIELD_W    = 4;
  localparam int COUNT_FIELD_W  = 5;
  localparam int STATUS_FIELD_W = 3;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_PEEK   = 2'd3
  } oul_op_t;

  localparam logic [STATUS_FIELD_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_FIELD_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_FIELD_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_FIELD_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_FIELD_W-1:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]             mode;
    logic [KEY_FIELD_W-1:0] key;
  } oul_req_t;

  typedef struct packed {
    logic [STATUS_FIELD_W-1:0] status;
    logic                      found;
    logic [POS_FIELD_W-1:0]    position;
    logic [KEY_FIELD_W-1:0]    head_key;
    logic [COUNT_FIELD_W-1:0]  entry_count;
  } oul_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } oul_state_t;

  typedef struct packed {
    logic capture;
    logic do_delete;
    logic do_append;
  } oul_cell_ctl_t;

endpackage

@@ rtl/core/oul_cell.sv @@
// oul_cell: one list slot, holds a key and a valid flag
// compares against the request key, shifts from its right neighbor on delete
// depends on oul_pkg
module oul_cell
  import oul_pkg::*;
#(
  parameter int KEY_BITS = KeyBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  oul_cell_ctl_t       ctl,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic                right_valid,
  input  logic                left_valid,
  input  logic                hit_before,
  output logic [KEY_BITS-1:0] key,
  output logic                valid,
  output logic                hit_through
);

  logic match;

  assign hit_through = hit_before | match;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= valid && (key == req_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.do_delete && hit_through) begin
      valid <= right_valid;
    end else if (ctl.do_append && !valid && left_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_delete && hit_through) begin
      key <= right_key;
    end else if (ctl.do_append && !valid && left_valid) begin
      key <= req_key;
    end
  end

endmodule

@@ rtl/core/ordered_unique_id_list_unit.sv @@
// ordered_unique_id_list_unit: top level, request sequencer and chain of list cells
// depends on oul_pkg and oul_cell
// Each request (append unique, delete, search, peek head) occupies the unit for a
// compare cycle, in which every cell checks its key against the request key, and
// an update cycle, in which the chain shifts on delete or fills the first empty
// cell on append; busy is high for both. The result is presented with done for
// one cycle after that, and a new start is taken in that same cycle; start is
// ignored while busy is high, so requests do not overlap. The update cycle carries a hit flag that
// ripples through all DEPTH cells. Results must be taken when done is high. No
// clearing pass follows reset: the list is empty as soon as rst falls.
module ordered_unique_id_list_unit
  import oul_pkg::*;
#(
  parameter int DEPTH    = DepthDefault,
  parameter int KEY_BITS = KeyBitsDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  oul_req_t request,
  output logic     done,
  output oul_rsp_t result
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  oul_state_t          state, state_next;
  oul_cell_ctl_t       ctl;
  logic                capture, apply;
  logic [1:0]          req_mode;
  logic [KEY_BITS-1:0] req_key;
  logic [CNT_W-1:0]    occupancy;

  logic [KEY_BITS-1:0] cell_key   [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    hit_thru;
  logic [DEPTH-1:0]    hit_at;

  logic                any_hit, full;
  logic [IDX_W-1:0]    hit_pos;
  logic [8:0]          pos_wide;

  logic [STATUS_FIELD_W-1:0] rsp_status, rsp_status_next;
  logic                      rsp_found, rsp_found_next;
  logic [POS_FIELD_W-1:0]    rsp_pos, rsp_pos_next;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_MATCH;
      S_MATCH: state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    capture = 1'b0;
    apply   = 1'b0;
    unique case (state)
      S_IDLE:  busy = 1'b0;
      S_MATCH: begin
        busy    = 1'b1;
        capture = 1'b1;
      end
      S_APPLY: begin
        busy  = 1'b1;
        apply = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_mode <= request.mode;
      req_key  <= KEY_BITS'(request.key);
    end
  end

  // cell chain
  assign any_hit = hit_thru[DEPTH-1];
  assign full    = cell_valid[DEPTH-1];

  assign ctl.capture   = capture;
  assign ctl.do_delete = apply && (req_mode == OP_DELETE) && any_hit;
  assign ctl.do_append = apply && (req_mode == OP_APPEND) && !any_hit && !full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] right_key;
    logic                right_valid, left_valid, hit_before;

    if (i < DEPTH - 1) begin : g_right
      assign right_key   = cell_key[i+1];
      assign right_valid = cell_valid[i+1];
    end else begin : g_end
      assign right_key   = '0;
      assign right_valid = 1'b0;
    end

    if (i > 0) begin : g_left
      assign left_valid = cell_valid[i-1];
      assign hit_before = hit_thru[i-1];
    end else begin : g_head
      assign left_valid = 1'b1;
      assign hit_before = 1'b0;
    end

    assign hit_at[i] = hit_thru[i] & ~hit_before;

    oul_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .req_key    (req_key),
      .right_key  (right_key),
      .right_valid(right_valid),
      .left_valid (left_valid),
      .hit_before (hit_before),
      .key        (cell_key[i]),
      .valid      (cell_valid[i]),
      .hit_through(hit_thru[i])
    );
  end

  // keys are unique, so at most one cell matches
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_at[i]) hit_pos = hit_pos | IDX_W'(i);
    end
  end

  assign pos_wide = 9'(hit_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (ctl.do_append) begin
      occupancy <= occupancy + 1'b1;
    end else if (ctl.do_delete) begin
      occupancy <= occupancy - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= apply;
    end
  end

  always_comb begin
    rsp_status_next = ST_DONE;
    rsp_found_next  = 1'b0;
    rsp_pos_next    = '0;
    unique case (oul_op_t'(req_mode))
      OP_APPEND: begin
        if (any_hit) begin
          rsp_status_next = ST_DUP;
          rsp_found_next  = 1'b1;
          rsp_pos_next    = pos_wide[POS_FIELD_W-1:0];
        end else if (full) begin
          rsp_status_next = ST_FULL;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        if (any_hit) begin
          rsp_found_next = 1'b1;
          rsp_pos_next   = pos_wide[POS_FIELD_W-1:0];
        end else begin
          rsp_status_next = ST_MISSING;
        end
      end
      OP_PEEK: begin
        if (occupancy == '0) rsp_status_next = ST_EMPTY;
      end
      default: rsp_status_next = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      rsp_status <= rsp_status_next;
      rsp_found  <= rsp_found_next;
      rsp_pos    <= rsp_pos_next;
    end
  end

  // head and count read straight from the updated chain while done is high
  assign result.status      = rsp_status;
  assign result.found       = rsp_found;
  assign result.position    = rsp_pos;
  assign result.head_key    = cell_valid[0] ? KEY_FIELD_W'(cell_key[0]) : '0;
  assign result.entry_count = COUNT_FIELD_W'(occupancy);

endmodule

@@ test/oul_result_checker.sv @@
// oul_result_checker: watches the request and result channels of the list unit
// keeps its own copy of the list, predicts each result and compares field by field
// depends on oul_pkg
module oul_result_checker
  import oul_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  oul_req_t request,
  input  logic     done,
  input  oul_rsp_t result,
  output int       mismatches,
  output int       outstanding,
  output int       checked_count,
  output int       full_count,
  output int       dup_count,
  output int       peak_fill
);

  localparam logic [KEY_FIELD_W-1:0] KeyMask =
    {KEY_FIELD_W{1'b1}} >> (KEY_FIELD_W - KeyBitsDefault);

  logic [KEY_FIELD_W-1:0] held_keys [DepthDefault];
  int                     held_count;
  oul_rsp_t               expected_results [$];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    checked_count = 0;
    full_count    = 0;
    dup_count     = 0;
    peak_fill     = 0;
    held_count    = 0;
  end

  function automatic oul_rsp_t predict_list_op(input oul_req_t r);
    oul_rsp_t               p;
    logic [KEY_FIELD_W-1:0] k;
    int                     hit;
    k   = r.key & KeyMask;
    hit = -1;
    for (int i = 0; i < held_count; i++) begin
      if (hit < 0 && held_keys[i] == k) hit = i;
    end
    p = '0;
    p.status = ST_DONE;
    case (oul_op_t'(r.mode))
      OP_APPEND: begin
        if (hit >= 0) begin
          p.status   = ST_DUP;
          p.found    = 1'b1;
          p.position = POS_FIELD_W'(hit);
          dup_count++;
        end else if (held_count >= DepthDefault) begin
          p.status = ST_FULL;
          full_count++;
        end else begin
          held_keys[held_count] = k;
          held_count++;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          p.found    = 1'b1;
          p.position = POS_FIELD_W'(hit);
          for (int i = hit; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
        end else begin
          p.status = ST_MISSING;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          p.found    = 1'b1;
          p.position = POS_FIELD_W'(hit);
        end else begin
          p.status = ST_MISSING;
        end
      end
      default: begin
        if (held_count == 0) p.status = ST_EMPTY;
      end
    endcase
    p.head_key    = (held_count > 0) ? held_keys[0] : '0;
    p.entry_count = COUNT_FIELD_W'(held_count);
    if (held_count > peak_fill) peak_fill = held_count;
    return p;
  endfunction

  task automatic flag_field(input string field, input logic [KEY_FIELD_W-1:0] want,
                            input logic [KEY_FIELD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d: %s expected 0x%0h, got 0x%0h", checked_count, field, want, got);
  endtask

  always @(posedge clk) begin
    oul_rsp_t want;
    if (rst) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no request waiting: status %0d head 0x%0h count %0d",
                     result.status, result.head_key, result.entry_count);
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status)
            flag_field("status", KEY_FIELD_W'(want.status), KEY_FIELD_W'(result.status));
          if (result.found !== want.found)
            flag_field("found", KEY_FIELD_W'(want.found), KEY_FIELD_W'(result.found));
          if (result.position !== want.position)
            flag_field("position", KEY_FIELD_W'(want.position), KEY_FIELD_W'(result.position));
          if (result.head_key !== want.head_key)
            flag_field("head_key", want.head_key, result.head_key);
          if (result.entry_count !== want.entry_count)
            flag_field("entry_count", KEY_FIELD_W'(want.entry_count),
                       KEY_FIELD_W'(result.entry_count));
          checked_count++;
        end
      end
      if (start && !busy) expected_results.push_back(predict_list_op(request));
    end
    outstanding = expected_results.size();
  end

endmodule

@@ test/tb_ordered_unique_id_list_unit.sv @@
// tb_ordered_unique_id_list_unit: stimulus and verdict for the ordered unique id list unit
// directed corner requests, then bursts of random append/delete/search/peek requests
// depends on oul_pkg, ordered_unique_id_list_unit and oul_result_checker
module tb_ordered_unique_id_list_unit;
  import oul_pkg::*;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } op_mix_t;

  localparam int RandomRequests = 1200;
  localparam int PoolSize       = 24;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  oul_req_t request;
  logic     done;
  oul_rsp_t result;

  int mismatches;
  int outstanding;
  int checked_count;
  int full_count;
  int dup_count;
  int peak_fill;

  logic [KEY_FIELD_W-1:0] key_pool [PoolSize];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordered_unique_id_list_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  oul_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .done          (done),
    .result        (result),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .full_count    (full_count),
    .dup_count     (dup_count),
    .peak_fill     (peak_fill)
  );

  task automatic issue(input oul_op_t op, input logic [KEY_FIELD_W-1:0] key);
    @(negedge clk);
    start        <= 1'b1;
    request.mode <= op;
    request.key  <= key;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start       <= 1'b0;
      request.mode <= 2'($urandom);
      request.key  <= $urandom;
    end
  endtask

  function automatic oul_op_t pick_op(input op_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   return roll < 60 ? OP_APPEND : roll < 75 ? OP_DELETE :
                         roll < 90 ? OP_SEARCH : OP_PEEK;
      MIX_SHRINK: return roll < 15 ? OP_APPEND : roll < 65 ? OP_DELETE :
                         roll < 90 ? OP_SEARCH : OP_PEEK;
      default:    return roll < 35 ? OP_APPEND : roll < 60 ? OP_DELETE :
                         roll < 85 ? OP_SEARCH : OP_PEEK;
    endcase
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    op_mix_t mix;
    int      sent;
    int      burst;
    int      waited;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    for (int i = 0; i < PoolSize; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list corners, head duplicate and head delete
    issue(OP_PEEK, 32'hDEAD_BEEF);
    issue(OP_SEARCH, 32'h0);
    issue(OP_DELETE, 32'hFFFF_FFFF);
    issue(OP_APPEND, 32'h0);
    issue(OP_APPEND, 32'hFFFF_FFFF);
    issue(OP_APPEND, 32'h0);
    issue(OP_DELETE, 32'h0);
    issue(OP_PEEK, 32'h0);
    // fill to capacity, reject one more, then search the tail and delete mid-list
    for (int i = 1; i < DepthDefault; i++) issue(OP_APPEND, 32'h1111_1111 * i + i);
    issue(OP_APPEND, 32'h5555_AAAA);
    issue(OP_SEARCH, 32'h1111_1111 * (DepthDefault - 1) + (DepthDefault - 1));
    issue(OP_DELETE, 32'h1111_1111 * 7 + 7);

    sent = 0;
    mix  = MIX_EVEN;
    while (sent < RandomRequests) begin
      if (sent % 60 == 0) mix = op_mix_t'($urandom_range(0, 2));
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < RandomRequests; b++) begin
        issue(pick_op(mix), pick_key());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 7));
    end
    pause(1);

    waited = 0;
    while (outstanding != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    $display("%0d results checked over %0d random and directed requests", checked_count,
             sent + 26);
    $display("list reached %0d entries; %0d full rejections, %0d duplicate appends",
             peak_fill, full_count, dup_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
